// ===== design/mm_pkg.sv =====
// Shared types and constants for the matrix multiply block.
package mm_pkg;

    localparam int MAX_DIM = 8;

    localparam logic [1:0] REQ_WRITE_A  = 2'd0;
    localparam logic [1:0] REQ_WRITE_B  = 2'd1;
    localparam logic [1:0] REQ_COMPUTE  = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    localparam logic [1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [1:0] CFG_COLS_B    = 2'd2;

    typedef enum logic [1:0] {
        t_ST_IDLE,
        t_ST_CALC,
        t_ST_DRAIN
    } t_state;

endpackage

// ===== design/mm_cell.sv =====
// One multiply-accumulate cell of the chain: holds one stored column of B.
module mm_cell #(
    parameter int MAX_DIM = 8,
    parameter int KW      = 3
) (
    input  logic                i_clk,
    input  logic                i_wr,
    input  logic [KW-1:0]       i_wr_k,
    input  logic signed [31:0]  i_wr_val,
    input  logic                i_clr,
    input  logic                i_acc,
    input  logic [KW-1:0]       i_k,
    input  logic signed [31:0]  i_a,
    output logic signed [31:0]  o_a,
    output logic signed [79:0]  o_sum
);
    logic signed [31:0] r_col [MAX_DIM];
    logic signed [31:0] r_a;
    logic signed [79:0] r_sum;
    logic signed [63:0] w_prod;

    assign w_prod = i_a * r_col[i_k];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_col[i_wr_k] <= i_wr_val;
        end
        r_a <= i_a;
        if (i_clr) begin
            r_sum <= '0;
        end else if (i_acc) begin
            r_sum <= r_sum + 80'(w_prod);
        end
    end

    assign o_a   = r_a;
    assign o_sum = r_sum;
endmodule

// ===== design/matrix_multiply.sv =====
// Matrix multiply top level: stores, cell chain, control and output stage.
// A write request stores one element of A or B. A compute request runs each
// row of A through a chain of MAX_DIM cells, one cell per column of B:
// element k of the row passes through the cells in order, and when the row
// has cleared the chain its cols_b results leave one a cycle through the
// output register while the receiver is ready. No new item is taken until
// the compute request is done, output stalls included.
module matrix_multiply #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // req_type, row_index, col_index, elem_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // out_row, out_col, product_value, saturated
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    localparam int MAX_DIM = mm_pkg::MAX_DIM;
    localparam int KW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(MAX_DIM + 1) + 1;
    localparam logic [3:0] DIM_MAX = 4'(MAX_DIM);

    logic [1:0]         w_req;
    logic [2:0]         w_row, w_col;
    logic signed [31:0] w_val;
    assign w_req = s_axis_tdata[1:0];
    assign w_row = s_axis_tdata[4:2];
    assign w_col = s_axis_tdata[7:5];
    assign w_val = s_axis_tdata[39:8];

    logic [3:0] r_rows, r_inner, r_cols;
    logic [3:0] w_m, w_n, w_c;

    function automatic logic [3:0] clamp(input logic [3:0] d);
        if (d == 4'd0) return 4'd1;
        if (d > DIM_MAX) return DIM_MAX;
        return d;
    endfunction

    assign w_m = clamp(r_rows);
    assign w_n = clamp(r_inner);
    assign w_c = clamp(r_cols);

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= 4'd8;
            r_inner <= 4'd8;
            r_cols  <= 4'd8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mm_pkg::CFG_ROWS_A:    r_rows  <= i_cfg_data;
                mm_pkg::CFG_INNER_DIM: r_inner <= i_cfg_data;
                mm_pkg::CFG_COLS_B:    r_cols  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Left matrix memory, read one element a cycle.
    logic signed [31:0] r_amem [MAX_DIM*MAX_DIM];
    logic signed [31:0] r_a_rd;

    mm_pkg::t_state r_state, n_state;
    logic [3:0]     r_i;
    logic [CW-1:0]  r_t;
    logic [3:0]     r_j;
    logic           w_acc_in, w_wr_ok, w_take;

    assign s_axis_tready = (r_state == mm_pkg::t_ST_IDLE);
    assign w_take  = s_axis_tvalid && s_axis_tready;
    assign w_wr_ok = ({1'b0, w_row} < DIM_MAX) && ({1'b0, w_col} < DIM_MAX);
    assign w_acc_in = (r_state == mm_pkg::t_ST_CALC) && (r_t < CW'(w_n));

    always_ff @(posedge i_clk) begin
        if (w_take && w_req == mm_pkg::REQ_WRITE_A && w_wr_ok) begin
            r_amem[{w_row[KW-1:0], w_col[KW-1:0]}] <= w_val;
        end
        r_a_rd <= r_amem[{r_i[KW-1:0], r_t[KW-1:0]}];
    end

    // Cell chain: cell j holds column j of B, A elements ripple right.
    logic signed [31:0] w_a   [MAX_DIM+1];
    logic signed [79:0] w_sum [MAX_DIM];
    logic [KW-1:0]      r_kd  [MAX_DIM];
    logic               r_vd  [MAX_DIM];

    assign w_a[0]  = r_a_rd;

    // Valid and index travel beside the A word, one stage per cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < MAX_DIM; q++) r_vd[q] <= 1'b0;
        end else begin
            r_vd[0] <= w_acc_in;
            for (int q = 1; q < MAX_DIM; q++) r_vd[q] <= r_vd[q-1];
        end
        r_kd[0] <= r_t[KW-1:0];
        for (int q = 1; q < MAX_DIM; q++) r_kd[q] <= r_kd[q-1];
    end

    genvar g;
    generate
        for (g = 0; g < MAX_DIM; g++) begin : g_cell
            logic w_wr;
            assign w_wr = w_take && w_req == mm_pkg::REQ_WRITE_B && w_wr_ok
                          && w_col[KW-1:0] == KW'(g);
            mm_cell #(.MAX_DIM(MAX_DIM), .KW(KW)) u_cell (
                .i_clk   (i_clk),
                .i_wr    (w_wr),
                .i_wr_k  (w_row[KW-1:0]),
                .i_wr_val(w_val),
                .i_clr   (r_state == mm_pkg::t_ST_CALC && r_t == '0),
                .i_acc   (r_vd[g]),
                .i_k     (r_kd[g]),
                .i_a     (w_a[g]),
                .o_a     (w_a[g+1]),
                .o_sum   (w_sum[g])
            );
        end
    endgenerate

    // Output stage: scale and saturate the selected column sum.
    logic signed [79:0] w_sel, w_shift;
    logic               w_hi, w_lo;
    logic               r_ovld, r_osat, r_olast;
    logic [2:0]         r_orow, r_ocol;
    logic [31:0]        r_oval;
    logic               w_emit;

    assign w_sel   = w_sum[r_j[KW-1:0]];
    assign w_shift = w_sel >>> FRAC_BITS;
    assign w_hi    = w_shift > 80'sh7FFFFFFF;
    assign w_lo    = w_shift < -80'sh80000000;
    assign w_emit  = (r_state == mm_pkg::t_ST_DRAIN) && (!r_ovld || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            mm_pkg::t_ST_IDLE:
                if (w_take && w_req == mm_pkg::REQ_COMPUTE) n_state = mm_pkg::t_ST_CALC;
            mm_pkg::t_ST_CALC:
                if (r_t == CW'(w_n) + CW'(MAX_DIM) + CW'(1)) n_state = mm_pkg::t_ST_DRAIN;
            mm_pkg::t_ST_DRAIN:
                if (w_emit && r_j + 4'd1 == w_c)
                    n_state = (r_i + 4'd1 == w_m) ? mm_pkg::t_ST_IDLE : mm_pkg::t_ST_CALC;
            default: n_state = mm_pkg::t_ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mm_pkg::t_ST_IDLE;
            r_i     <= '0;
            r_t     <= '0;
            r_j     <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                mm_pkg::t_ST_IDLE: begin
                    r_i <= '0;
                    r_t <= '0;
                    r_j <= '0;
                end
                mm_pkg::t_ST_CALC: r_t <= r_t + CW'(1);
                mm_pkg::t_ST_DRAIN:
                    if (w_emit) begin
                        if (r_j + 4'd1 == w_c) begin
                            r_j <= '0;
                            r_t <= '0;
                            r_i <= r_i + 4'd1;
                        end else begin
                            r_j <= r_j + 4'd1;
                        end
                    end
                default: ;
            endcase
            if (w_emit) r_ovld <= 1'b1;
            else if (m_axis_tready) r_ovld <= 1'b0;
        end
        if (w_emit) begin
            r_orow  <= r_i[2:0];
            r_ocol  <= r_j[2:0];
            r_osat  <= w_hi || w_lo;
            r_oval  <= w_hi ? 32'h7FFFFFFF : (w_lo ? 32'h80000000 : w_shift[31:0]);
            r_olast <= (r_i + 4'd1 == w_m) && (r_j + 4'd1 == w_c);
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {1'b0, r_osat, r_oval, r_ocol, r_orow};
    assign m_axis_tlast  = r_olast;
endmodule

// ===== dv/tb_top.sv =====
// Matrix multiply testbench: directed and random loads and computes, checked by a predictor.
`timescale 1ns / 100ps

module tb_top;
    localparam int DIM = mm_pkg::MAX_DIM;
    localparam int QUIET_LIMIT = 20000;
    localparam int ITEM_TARGET = 350;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  col;
        logic [2:0]  row;
        logic [1:0]  req;
    } t_req_word;

    typedef struct packed {
        logic        last;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        sat;
    } t_prod_elem;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [3:0]  i_cfg_data = '0;

    matrix_multiply dut (.*);

    initial forever #2 i_clk = ~i_clk;

    t_req_word   pending_reqs[$];
    t_prod_elem  expected_prods[$];
    logic [31:0] left_mat[DIM*DIM];
    logic [31:0] right_mat[DIM*DIM];
    bit          left_seen[DIM*DIM];
    bit          right_seen[DIM*DIM];
    logic [3:0]  dim_rows = 4'd8, dim_inner = 4'd8, dim_cols = 4'd8;
    int          send_idle_pct = 0, recv_idle_pct = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;
    int          queued = 0;
    bit          in_taken = 1'b0;

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic int eff_dim(input logic [3:0] d);
        if (d == 0) return 1;
        if (d > DIM) return DIM;
        return d;
    endfunction

    // Exact wide sum, floor shift, clip to 32 bits.
    function automatic t_prod_elem dot_product(input int i, input int j, input int n);
        logic signed [79:0] acc;
        logic signed [79:0] shifted;
        t_prod_elem e;
        acc = '0;
        for (int k = 0; k < n; k++)
            acc += 80'(signed'(left_mat[i*DIM+k])) * 80'(signed'(right_mat[k*DIM+j]));
        shifted = acc >>> 16;
        e = '0;
        e.row = 3'(i);
        e.col = 3'(j);
        if (shifted > 80'sh7FFFFFFF) begin
            e.value = 32'h7FFFFFFF;
            e.sat = 1'b1;
        end else if (shifted < -80'sh80000000) begin
            e.value = 32'h80000000;
            e.sat = 1'b1;
        end else begin
            e.value = shifted[31:0];
        end
        return e;
    endfunction

    task automatic predict_request(input t_req_word w);
        int m, n, c;
        t_prod_elem e;
        if (w.req == mm_pkg::REQ_WRITE_A) begin
            left_mat[w.row*DIM+w.col] = w.value;
        end else if (w.req == mm_pkg::REQ_WRITE_B) begin
            right_mat[w.row*DIM+w.col] = w.value;
        end else if (w.req == mm_pkg::REQ_COMPUTE) begin
            m = eff_dim(dim_rows);
            n = eff_dim(dim_inner);
            c = eff_dim(dim_cols);
            for (int i = 0; i < m; i++)
                for (int j = 0; j < c; j++) begin
                    e = dot_product(i, j, n);
                    e.last = (i == m - 1) && (j == c - 1);
                    expected_prods.push_back(e);
                end
        end
    endtask

    // Driver: present a word on the falling edge, advance on acceptance.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || in_taken) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tdata <= pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predict accepted words, check result words.
    always @(posedge i_clk) begin
        t_prod_elem got, exp_e;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_request(t_req_word'(s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tlast, m_axis_tdata[2:0], m_axis_tdata[5:3],
                       m_axis_tdata[37:6], m_axis_tdata[38]};
                if (expected_prods.size() == 0) begin
                    report($sformatf("unexpected result %h", m_axis_tdata));
                end else begin
                    exp_e = expected_prods.pop_front();
                    if (got.row != exp_e.row)
                        report($sformatf("row %0d exp %0d", got.row, exp_e.row));
                    if (got.col != exp_e.col)
                        report($sformatf("col %0d exp %0d", got.col, exp_e.col));
                    if (got.value != exp_e.value)
                        report($sformatf("[%0d][%0d] value %h exp %h",
                                         exp_e.row, exp_e.col, got.value, exp_e.value));
                    if (got.sat != exp_e.sat)
                        report($sformatf("[%0d][%0d] sat %b exp %b",
                                         exp_e.row, exp_e.col, got.sat, exp_e.sat));
                    if (got.last != exp_e.last)
                        report($sformatf("[%0d][%0d] last %b exp %b",
                                         exp_e.row, exp_e.col, got.last, exp_e.last));
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(32'h3FFFF) - 32'h20000;  // small, around +-2
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_write(input logic [1:0] kind, input int r, input int c,
                               input logic [31:0] v);
        t_req_word w;
        w.req = kind;
        w.row = 3'(r);
        w.col = 3'(c);
        w.value = v;
        pending_reqs.push_back(w);
        queued++;
        if (kind == mm_pkg::REQ_WRITE_A) left_seen[r*DIM+c] = 1;
        if (kind == mm_pkg::REQ_WRITE_B) right_seen[r*DIM+c] = 1;
    endtask

    task automatic queue_compute();
        t_req_word w;
        w.req = mm_pkg::REQ_COMPUTE;
        w.row = 3'($urandom);
        w.col = 3'($urandom);
        w.value = $urandom;
        pending_reqs.push_back(w);
        queued++;
    endtask

    // Fill store entries the current shape reads but has not seen, and rewrite seen ones at random.
    task automatic queue_cover_writes();
        int m, n, c;
        m = eff_dim(dim_rows);
        n = eff_dim(dim_inner);
        c = eff_dim(dim_cols);
        for (int i = 0; i < m; i++)
            for (int k = 0; k < n; k++)
                if (!left_seen[i*DIM+k] || $urandom_range(3) == 0)
                    queue_write(mm_pkg::REQ_WRITE_A, i, k, rand_elem());
        for (int k = 0; k < n; k++)
            for (int j = 0; j < c; j++)
                if (!right_seen[k*DIM+j] || $urandom_range(3) == 0)
                    queue_write(mm_pkg::REQ_WRITE_B, k, j, rand_elem());
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_prods.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [3:0] val);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == mm_pkg::CFG_ROWS_A) dim_rows = val;
        else if (idx == mm_pkg::CFG_INNER_DIM) dim_inner = val;
        else if (idx == mm_pkg::CFG_COLS_B) dim_cols = val;
    endtask

    task automatic set_shape(input logic [3:0] r, input logic [3:0] n, input logic [3:0] c);
        wait_idle();
        write_cfg(mm_pkg::CFG_ROWS_A, r);
        write_cfg(mm_pkg::CFG_INNER_DIM, n);
        write_cfg(mm_pkg::CFG_COLS_B, c);
    endtask

    initial begin
        int base;
        int goal;
        t_req_word w;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: tiny shape with extreme values and saturation both ways.
        set_shape(4'd1, 4'd1, 4'd1);
        queue_write(mm_pkg::REQ_WRITE_A, 0, 0, 32'h7FFFFFFF);
        queue_write(mm_pkg::REQ_WRITE_B, 0, 0, 32'h7FFFFFFF);
        queue_compute();
        queue_write(mm_pkg::REQ_WRITE_B, 0, 0, 32'h80000000);
        queue_compute();
        queue_write(mm_pkg::REQ_WRITE_A, 0, 0, 32'hFFFFFFFF);   // floor of a tiny negative
        queue_write(mm_pkg::REQ_WRITE_B, 0, 0, 32'h00000001);
        queue_compute();
        queue_write(mm_pkg::REQ_WRITE_A, 0, 0, 32'h80000000);
        queue_write(mm_pkg::REQ_WRITE_B, 0, 0, 32'h80000000);
        queue_compute();
        // Writes at the last store index lie outside the current shape; unused request code is ignored.
        w.req = mm_pkg::REQ_RESERVED;
        w.row = 3'd7;
        w.col = 3'd7;
        w.value = 32'h12345678;
        pending_reqs.push_back(w);
        queued++;
        queue_write(mm_pkg::REQ_WRITE_A, 7, 7, 32'h00010000);
        queue_write(mm_pkg::REQ_WRITE_B, 7, 7, 32'hFFFF0000);
        queue_compute();
        // Zero dimensions act as one; a value above the limit acts as the limit.
        set_shape(4'd0, 4'd0, 4'd0);
        queue_compute();
        set_shape(4'd15, 4'd9, 4'd15);
        queue_cover_writes();
        queue_compute();

        base = queued;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 87 : 0;
            recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 9 : 0;
            goal = base + (ITEM_TARGET - base) * (phase + 1) / 3;
            while (queued < goal) begin
                // Mostly shapes with small inner and column sizes, occasionally the full size.
                if ($urandom_range(5) == 0)
                    set_shape(4'd8, 4'd8, 4'd8);
                else
                    set_shape(4'($urandom_range(15)), 4'($urandom_range(4)),
                              4'($urandom_range(4)));
                for (int b = 0; b < 3; b++) begin
                    queue_cover_writes();
                    queue_compute();
                end
                wait_idle();
            end
        end
        wait_idle();
        repeat (100) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
